### hdl/bhsv_pkg.sv
// ----------------------------------------------------------------------------
// bhsv_pkg
// shared types, register codes, reset values and the sine table builder
// ----------------------------------------------------------------------------
package bhsv_pkg;

    localparam int VOICES_DEF     = 16;
    localparam int TABLE_BITS_DEF = 10;

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    // input kinds carried on tuser
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAK,
        CFG_COEF_FUND,
        CFG_COEF_SECOND,
        CFG_COEF_IMPULSE
    } t_cfg_reg;

    localparam logic        [23:0] LEAK_RST         = 24'd8346665;
    localparam logic signed [23:0] COEF_FUND_RST    = -24'sd891756;
    localparam logic signed [23:0] COEF_SECOND_RST  = 24'sd306542;
    localparam logic signed [23:0] COEF_IMPULSE_RST = 24'sd2465349;

    localparam logic [31:0] PHASE_START = 32'h8000_0000;
    localparam logic [31:0] EDGE_LO     = 32'd43;
    localparam logic [31:0] EDGE_HI     = 32'hFFFF_FFD4;
    localparam logic [31:0] QUARTER     = 32'h4000_0000;

    // impulse divider: |c*m| >> 16 has at most 47 significant bits
    localparam int DIV_BITS = 47;
    localparam int DCNT_W   = 6;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic        [31:0] key;
        logic        [15:0] loud;
        logic        [31:0] phase;
        logic        [31:0] step;
        logic        [14:0] harm;
        logic signed [31:0] integ;
        logic signed [31:0] out;
    } t_voice;

    // quarter-wave taylor series in q30, evaluated at elaboration only
    function automatic logic signed [15:0] sine_q15(input logic [31:0] p);
        logic        [63:0] r;
        logic        [63:0] x;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        r = {34'd0, p[29:0]};
        if (p[30]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * PI_HALF_Q30) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        if (p[31]) begin
            v = -v;
        end
        return v[15:0];
    endfunction

endpackage

### hdl/blit_hardsync_sine_voices.sv
// a note-on is written straight from idle; a note-off walks the voice memory a voice at a time
// (read, then compare); a tick reads and loads each voice; a sounding one runs P1 to P8 and,
// with three or more harmonics, the 47-step divider and INT1 to INT4; the result is loaded last
// throughput: one item at a time; the input stalls until the current item is finished
// reset: synchronous, active low; clears voice flags, key-valid flags, the output register and
// restores the register defaults; the voice memory itself is not cleared
// ----------------------------------------------------------------------------
// blit_hardsync_sine_voices
// polyphonic hard-synced sine oscillator with a band-limited impulse train
// ----------------------------------------------------------------------------
module blit_hardsync_sine_voices #(
    parameter int VOICES     = bhsv_pkg::VOICES_DEF,
    parameter int TABLE_BITS = bhsv_pkg::TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] note_key, [47:32] loudness, [79:48] phase_step, [94:80] harmonic_limit
    input  logic [bhsv_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [1:0] mode
    input  logic [bhsv_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    // results
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [31:0] sample
    output logic [bhsv_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [0] silent
    output logic                                o_m_tuser,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bhsv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bhsv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bhsv_pkg::*;

    localparam int VW       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ROM_SIZE = (1 << TABLE_BITS) + 1;
    localparam int MIX_W    = 50 + $clog2(VOICES + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ORD, ST_OCMP, ST_TRD, ST_LOAD,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
        ST_DIV, ST_INT1, ST_INT2, ST_INT3, ST_INT4, ST_WB, ST_DONE
    } t_state;

    // round half up then floor shift
    function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] v,
                                                  input int unsigned sh);
        return (v + (66'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    t_state r_state;
    logic [VW-1:0] r_vidx;
    logic [VOICES-1:0] r_on;
    logic [VOICES-1:0] r_kval;   // key written since reset, else the key reads as zero
    logic r_silent;

    logic              r_m_tvalid;
    logic signed [31:0] r_sample;
    logic              r_out_silent;

    logic        [23:0] r_leak;
    logic signed [23:0] r_coef_fund;
    logic signed [23:0] r_coef_second;
    logic signed [23:0] r_coef_impulse;

    // voice memory, one read and one write port
    t_voice r_mem [VOICES];
    t_voice r_ent;
    logic          w_we;
    logic [VW-1:0] w_waddr;
    t_voice        w_wdata;

    // sine table and its registered two-entry read
    logic signed [15:0] w_rom [ROM_SIZE];
    logic        [31:0] w_lx;
    logic [TABLE_BITS:0] w_li0;
    logic [TABLE_BITS:0] w_li1;
    logic signed [15:0] r_ra;
    logic signed [15:0] r_rb;
    logic        [15:0] r_rf;
    logic        [16:0] w_wa;
    logic signed [34:0] w_lkw;
    logic signed [31:0] w_lk;

    // shared multiplier
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] r_prod;

    // datapath registers
    logic        [31:0] r_t;
    logic signed [31:0] r_st;
    logic signed [31:0] r_c;
    logic signed [31:0] r_m;
    logic signed [31:0] r_d;
    logic signed [31:0] r_s2;
    logic signed [39:0] r_acc;
    logic signed [35:0] r_il;
    logic signed [31:0] r_b;
    logic signed [31:0] r_integ;
    logic               r_dok;
    logic        [31:0] r_key;
    logic signed [MIX_W-1:0] r_mix;

    // divider
    logic               r_dbusy;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [DIV_BITS-1:0] r_dnum;
    logic        [31:0] r_rem;
    logic        [31:0] r_dden;
    logic               r_dneg;
    logic        [32:0] w_trial;
    logic               w_qbit;
    logic        [31:0] w_rem_nx;
    logic signed [65:0] w_cm_mag;
    logic signed [31:0] w_qsat;
    logic               w_dstart;

    logic          w_free_ok;
    logic [VW-1:0] w_free_idx;
    logic          w_in_xfer;
    logic          w_last;
    logic [31:0]   w_keycmp;
    logic [31:0]   w_fallback;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_sample;
    assign o_m_tuser   = r_out_silent;

    assign w_in_xfer = i_s_tvalid && o_s_tready;
    assign w_last    = (r_vidx == VW'(VOICES - 1));
    assign w_keycmp  = r_kval[r_vidx] ? r_ent.key : 32'd0;
    // edge fallback n-2 scaled to q16.15
    assign w_fallback = ({17'd0, r_ent.harm} - 32'd2) << 15;

    // table entries are constants folded at elaboration
    for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
        assign w_rom[gi] = sine_q15(32'(64'(gi) << (32 - TABLE_BITS)));
    end

    // lowest free voice for note-on
    always_comb begin
        w_free_ok  = 1'b0;
        w_free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_on[i]) begin
                w_free_ok  = 1'b1;
                w_free_idx = VW'(i);
            end
        end
    end

    // memory write: note-on load or voice writeback
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_vidx;
        w_wdata = r_ent;
        if (r_state == ST_WB) begin
            w_we          = 1'b1;
            w_wdata.phase = r_t;
            w_wdata.integ = (r_ent.harm >= 15'd3) ? r_integ : 32'sd0;
            w_wdata.out   = sat32(48'(r_acc));
        end else if (w_in_xfer && (i_s_tuser == MODE_NOTE_ON) && w_free_ok) begin
            w_we          = 1'b1;
            w_waddr       = w_free_idx;
            w_wdata.key   = i_s_tdata[31:0];
            w_wdata.loud  = i_s_tdata[47:32];
            w_wdata.phase = PHASE_START;
            w_wdata.step  = i_s_tdata[79:48];
            w_wdata.harm  = i_s_tdata[94:80];
            w_wdata.integ = 32'sd0;
            w_wdata.out   = 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_ent <= r_mem[r_vidx];
    end

    // lookup argument per step: t, the two impulse phases, t/2 and 2t
    always_comb begin
        unique case (r_state)
            ST_P2:   w_lx = r_prod[32:1] + QUARTER;
            ST_P3:   w_lx = r_prod[32:1];
            ST_P4:   w_lx = {1'b0, r_t[31:1]};
            ST_P5:   w_lx = {r_t[30:0], 1'b0};
            default: w_lx = r_t;
        endcase
    end

    assign w_li0 = {1'b0, w_lx[31 -: TABLE_BITS]};
    assign w_li1 = w_li0 + 1'b1;

    always_ff @(posedge i_clk) begin
        r_ra <= w_rom[w_li0];
        r_rb <= w_rom[w_li1];
        r_rf <= w_lx[31-TABLE_BITS -: 16];
    end

    // linear interpolation, q1.31
    assign w_wa  = 17'h1_0000 - {1'b0, r_rf};
    assign w_lkw = 35'(r_ra * $signed({1'b0, w_wa})) + 35'(r_rb * $signed({2'b0, r_rf}));
    assign w_lk  = w_lkw[31:0];

    // operand selection for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_LOAD: begin
                w_ma = 33'(r_ent.out);
                w_mb = 33'(r_ent.loud);
            end
            ST_P1: begin
                w_ma = 33'(r_t);
                w_mb = 33'(r_ent.harm) + 33'd3;
            end
            ST_P2: begin
                w_ma = 33'(r_t);
                w_mb = 33'(r_ent.harm) - 33'd2;
            end
            ST_P3: begin
                w_ma = 33'(r_coef_fund);
                w_mb = 33'(r_st);
            end
            ST_P4: begin
                w_ma = 33'(r_ent.integ);
                w_mb = 33'(r_leak);
            end
            ST_P5: begin
                w_ma = 33'(r_c);
                w_mb = 33'(r_m);
            end
            ST_P7: begin
                w_ma = 33'(r_coef_second);
                w_mb = 33'(r_s2);
            end
            ST_INT1: begin
                w_ma = 33'(r_b);
                w_mb = 33'(r_ent.step[31:8]);
            end
            ST_INT3: begin
                w_ma = 33'(r_coef_impulse);
                w_mb = 33'(r_integ);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // restoring divider: (|c*m| >> 16) / d, one quotient bit a cycle
    assign w_dstart = (r_state == ST_P6);
    assign w_cm_mag = r_prod[65] ? -r_prod : r_prod;
    assign w_trial  = {r_rem, r_dnum[DIV_BITS-1]};
    assign w_qbit   = (w_trial >= {1'b0, r_dden});
    assign w_rem_nx = w_qbit ? 32'(w_trial - {1'b0, r_dden}) : w_trial[31:0];

    always_comb begin
        if (r_dneg) begin
            w_qsat = (r_dnum > DIV_BITS'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                           : 32'(-r_dnum);
        end else begin
            w_qsat = (r_dnum > DIV_BITS'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                           : r_dnum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (w_dstart) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= DCNT_W'(DIV_BITS);
            r_dnum  <= w_cm_mag[62:16];
            r_rem   <= '0;
            r_dden  <= r_d;
            r_dneg  <= r_prod[65];
        end else if (r_dbusy) begin
            r_dnum <= {r_dnum[DIV_BITS-2:0], w_qbit};
            r_rem  <= w_rem_nx;
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == DCNT_W'(1)) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    // per-voice datapath, stepped by the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_mix <= '0;
                r_key <= i_s_tdata[31:0];
            end
            ST_LOAD: r_t <= r_ent.phase + r_ent.step;
            ST_P1:   r_mix <= r_mix + MIX_W'(r_prod);
            ST_P2:   r_st <= w_lk;
            ST_P3:   r_c <= w_lk;
            ST_P4: begin
                r_m   <= w_lk;
                r_acc <= 40'(rnd_sh(r_prod, 28));
            end
            ST_P5: begin
                r_d  <= w_lk;
                r_il <= 36'(rnd_sh(r_prod, 23));
            end
            ST_P6: begin
                r_s2  <= w_lk;
                r_dok <= (r_t >= EDGE_LO) && (r_t <= EDGE_HI) && (r_d > 32'sd0);
            end
            ST_P8: begin
                if (r_ent.harm >= 15'd2) begin
                    r_acc <= r_acc + 40'(rnd_sh(r_prod, 28));
                end
            end
            ST_DIV: r_b <= r_dok ? w_qsat : w_fallback;
            ST_INT2: r_integ <= sat32(48'(r_il) + 48'(rnd_sh(r_prod, 16)));
            ST_INT4: r_acc <= r_acc + 40'(rnd_sh(r_prod, 20));
            default: begin
            end
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak         <= LEAK_RST;
            r_coef_fund    <= COEF_FUND_RST;
            r_coef_second  <= COEF_SECOND_RST;
            r_coef_impulse <= COEF_IMPULSE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LEAK:         r_leak         <= i_cfg_data;
                CFG_COEF_FUND:    r_coef_fund    <= i_cfg_data;
                CFG_COEF_SECOND:  r_coef_second  <= i_cfg_data;
                CFG_COEF_IMPULSE: r_coef_impulse <= i_cfg_data;
            endcase
        end
    end

    // sequencer, voice flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vidx       <= '0;
            r_on         <= '0;
            r_kval       <= '0;
            r_silent     <= 1'b1;
            r_m_tvalid   <= 1'b0;
            r_sample     <= '0;
            r_out_silent <= 1'b0;
        end else begin
            // result leaves on its transfer; the final tick step reloads it itself
            if (r_m_tvalid && i_m_tready && (r_state != ST_DONE)) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_vidx <= '0;
                    if (w_in_xfer) begin
                        unique case (i_s_tuser)
                            MODE_TICK: begin
                                r_silent <= 1'b1;
                                r_state  <= ST_TRD;
                            end
                            MODE_NOTE_ON: begin
                                if (w_free_ok) begin
                                    r_on[w_free_idx]   <= 1'b1;
                                    r_kval[w_free_idx] <= 1'b1;
                                end
                            end
                            MODE_NOTE_OFF: r_state <= ST_ORD;
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ORD: r_state <= ST_OCMP;
                ST_OCMP: begin
                    // first key match ends the search, even on a voice already off
                    if (w_keycmp == r_key) begin
                        r_on[r_vidx] <= 1'b0;
                        r_state      <= ST_IDLE;
                    end else if (w_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_vidx  <= r_vidx + 1'b1;
                        r_state <= ST_ORD;
                    end
                end
                ST_TRD: r_state <= ST_LOAD;
                ST_LOAD: begin
                    if (r_on[r_vidx]) begin
                        r_silent <= 1'b0;
                        r_state  <= ST_P1;
                    end else if (w_last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_vidx  <= r_vidx + 1'b1;
                        r_state <= ST_TRD;
                    end
                end
                ST_P1: r_state <= ST_P2;
                ST_P2: r_state <= ST_P3;
                ST_P3: r_state <= ST_P4;
                ST_P4: r_state <= ST_P5;
                ST_P5: r_state <= ST_P6;
                ST_P6: r_state <= ST_P7;
                ST_P7: r_state <= ST_P8;
                ST_P8: r_state <= (r_ent.harm >= 15'd3) ? ST_DIV : ST_WB;
                ST_DIV: begin
                    if (!r_dbusy) begin
                        r_state <= ST_INT1;
                    end
                end
                ST_INT1: r_state <= ST_INT2;
                ST_INT2: r_state <= ST_INT3;
                ST_INT3: r_state <= ST_INT4;
                ST_INT4: r_state <= ST_WB;
                ST_WB: begin
                    if (w_last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_vidx  <= r_vidx + 1'b1;
                        r_state <= ST_TRD;
                    end
                end
                ST_DONE: begin
                    // wait for room in the output register
                    if (!r_m_tvalid || i_m_tready) begin
                        r_m_tvalid   <= 1'b1;
                        r_sample     <= sat32(48'(rnd_sh(66'(r_mix), 16)));
                        r_out_silent <= r_silent;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_wb_on_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> r_on[r_vidx])
        else $error("writeback to a voice that is off");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the final step of a tick");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && !r_dbusy) |=> (r_state == ST_INT1))
        else $error("divider wait did not release");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_out_silent) |-> (r_sample == 32'sd0))
        else $error("silent tick with a non-zero sample");
`endif

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the polyphonic hard-synced sine oscillator: a
// bit-true voice model predicts every mixed sample, and a clocked monitor
// compares each output transfer with the oldest predicted sample
// ----------------------------------------------------------------------------
module tb_top;
    import bhsv_pkg::*;

    localparam int NV       = 16;
    localparam int TAB_SIZE = 1025;
    localparam int PER_RUN  = 483;   // counted items per idling phase

    // kind that the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [15:0] loud;
        logic [31:0] step;
        logic [14:0] harm;
    } t_note_item;

    typedef struct {
        logic [31:0] sample;
        logic        silent;
    } t_mix_out;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // stimulus side
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_cfg_ready;

    // bench bookkeeping
    t_note_item  pending_items[$];
    t_mix_out    sample_q[$];
    logic        in_taken = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors = 0;
    int          n_ticks = 0;
    int          n_on = 0;
    int          n_off = 0;
    int          n_samples = 0;

    // voice model state
    logic signed [15:0] sine_tab [0:TAB_SIZE-1];
    logic               v_on   [NV];
    logic [31:0]        v_key  [NV];
    longint             v_loud [NV];
    logic [31:0]        v_phase[NV];
    logic [31:0]        v_step [NV];
    int unsigned        v_harm [NV];
    longint             v_integ[NV];
    longint             v_out  [NV];
    longint             leak_q;
    longint             fund_q;
    longint             second_q;
    longint             impulse_q;

    always #2 i_clk = ~i_clk;

    blit_hardsync_sine_voices u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // fixed-point helpers
    // ------------------------------------------------------------------

    // quarter-wave taylor series in q30, rounded to q1.15
    function automatic logic signed [15:0] sine_entry(input logic [31:0] p);
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          v;
        r = p[29:0];
        if (p[30]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * PI_HALF_Q30) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + 16384) >>> 15;
        if (v > 32767) begin
            v = 32767;
        end
        if (p[31]) begin
            v = -v;
        end
        return v[15:0];
    endfunction

    // add half then floor shift
    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // linear interpolation between table entries, result in q1.31
    function automatic longint sine_at(input logic [31:0] x);
        int unsigned idx;
        longint      f;
        idx = x[31:22];
        f   = longint'(x[21:6]);
        return longint'(sine_tab[idx]) * (65536 - f) + longint'(sine_tab[idx+1]) * f;
    endfunction

    // band-limited impulse train, q16.15
    function automatic longint blit_value(input logic [31:0] t, input int unsigned n);
        longint unsigned n1;
        longint          n2;
        longint unsigned prod;
        logic [31:0]     arg_c;
        logic [31:0]     arg_m;
        longint          c;
        longint          m;
        longint          d;
        n1    = longint'(n) + 3;
        n2    = longint'(n) - 2;
        prod  = (longint'(t) * n1) >> 1;
        arg_c = prod[31:0] + QUARTER;
        prod  = (longint'(t) * longint'(n2)) >> 1;
        arg_m = prod[31:0];
        c = sine_at(arg_c);
        m = sine_at(arg_m);
        d = sine_at(t >> 1);
        // near the period edges or with no divisor the train falls back to a constant
        if (t >= EDGE_LO && t <= EDGE_HI && d > 0) begin
            return clip32((c * m) / (d * 65536));
        end
        return n2 * 32768;
    endfunction

    function automatic void advance_voice(input int v);
        logic [31:0] t;
        longint      acc;
        longint      b;
        longint      integ;
        t          = v_phase[v] + v_step[v];
        v_phase[v] = t;
        acc = round_shift(fund_q * sine_at(t), 28);
        if (v_harm[v] >= 2) begin
            acc += round_shift(second_q * sine_at(t << 1), 28);
        end
        if (v_harm[v] >= 3) begin
            b     = blit_value(t, v_harm[v]);
            integ = round_shift(v_integ[v] * leak_q, 23)
                  + round_shift(b * longint'(v_step[v] >> 8), 16);
            v_integ[v] = clip32(integ);
            acc += round_shift(impulse_q * v_integ[v], 20);
        end else begin
            v_integ[v] = 0;
        end
        v_out[v] = clip32(acc);
    endfunction

    // applies one accepted item to the voice model and queues the sample a tick yields
    function automatic void voice_update(input logic [1:0] mode, input logic [IN_TDATA_W-1:0] d);
        longint   mix;
        t_mix_out r;
        case (mode)
            MODE_NOTE_ON: begin
                n_on++;
                for (int v = 0; v < NV; v++) begin
                    if (!v_on[v]) begin
                        v_on[v]    = 1'b1;
                        v_key[v]   = d[31:0];
                        v_loud[v]  = longint'(d[47:32]);
                        v_step[v]  = d[79:48];
                        v_harm[v]  = d[94:80];
                        v_phase[v] = PHASE_START;
                        v_integ[v] = 0;
                        v_out[v]   = 0;
                        break;
                    end
                end
            end
            MODE_NOTE_OFF: begin
                n_off++;
                // first matching key wins, even if that voice is already off
                for (int v = 0; v < NV; v++) begin
                    if (v_key[v] == d[31:0]) begin
                        v_on[v] = 1'b0;
                        break;
                    end
                end
            end
            MODE_TICK: begin
                n_ticks++;
                mix      = 0;
                r.silent = 1'b1;
                for (int v = 0; v < NV; v++) begin
                    if (v_on[v]) begin
                        r.silent = 1'b0;
                        mix += v_out[v] * v_loud[v];
                    end
                end
                r.sample = 32'(clip32(round_shift(mix, 16)));
                sample_q.push_back(r);
                for (int v = 0; v < NV; v++) begin
                    if (v_on[v]) begin
                        advance_voice(v);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // driver: at most one nonblocking update per signal at each falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_note_item it;
        if (i_rst_n) begin
            if (!s_valid || in_taken) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= {1'b0, it.harm, it.step, it.loud, it.key};
                    s_tuser <= it.mode;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------
    // monitor: transfers are taken at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_mix_out want;
        in_taken <= s_valid && o_s_tready;
        if (i_rst_n) begin
            if (s_valid && o_s_tready) begin
                voice_update(s_tuser, s_tdata);
            end
            if (o_m_tvalid && m_ready) begin
                n_samples++;
                if (sample_q.size() == 0) begin
                    report_mismatch("unexpected sample", o_m_tdata, 32'd0);
                end else begin
                    want = sample_q.pop_front();
                    if (o_m_tdata !== want.sample) begin
                        report_mismatch("sample", o_m_tdata, want.sample);
                    end
                    if (o_m_tuser !== want.silent) begin
                        report_mismatch("silent", {31'd0, o_m_tuser}, {31'd0, want.silent});
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    logic [31:0] key_pool[16];

    function automatic t_note_item mk_item(input logic [1:0] mode, input logic [31:0] key,
                                           input logic [15:0] loud, input logic [31:0] step,
                                           input logic [14:0] harm);
        t_note_item it;
        it.mode = mode;
        it.key  = key;
        it.loud = loud;
        it.step = step;
        it.harm = harm;
        return it;
    endfunction

    // mostly well-formed note traffic on a small key set, plus noise
    function automatic t_note_item random_item();
        t_note_item  it;
        int          r;
        logic [31:0] key;
        logic [31:0] step;
        logic [14:0] harm;
        r    = $urandom_range(99);
        key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(15)] : $urandom;
        case ($urandom_range(9))
            0:       step = 32'h8000_0000;
            1, 2:    step = $urandom_range(32'h7FFF_FFFF, 0);
            3:       step = $urandom_range(64, 0);
            default: step = $urandom_range(32'h0400_0000, 0);
        endcase
        case ($urandom_range(9))
            0:       harm = 15'($urandom_range(32767, 0));
            1, 2:    harm = 15'($urandom_range(2, 0));
            default: harm = 15'($urandom_range(60, 3));
        endcase
        it = mk_item(MODE_TICK, key, 16'($urandom), step, harm);
        if (r >= 97) begin
            it.mode = MODE_UNUSED;
        end else if (r >= 70) begin
            it.mode = MODE_NOTE_OFF;
        end else if (r >= 40) begin
            it.mode = MODE_NOTE_ON;
        end
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || sample_q.size() > 0) begin
            @(posedge i_clk);
        end
        // a trailing note-off may still be walking the voices
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg r, input logic [23:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= val;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        case (r)
            CFG_LEAK:        leak_q    = longint'(val);
            CFG_COEF_FUND:   fund_q    = longint'(signed'(val));
            CFG_COEF_SECOND: second_q  = longint'(signed'(val));
            default:         impulse_q = longint'(signed'(val));
        endcase
    endtask

    task automatic cfg_all(input logic [23:0] lk, input logic [23:0] c1,
                           input logic [23:0] c2, input logic [23:0] c3);
        cfg_write(CFG_LEAK, lk);
        cfg_write(CFG_COEF_FUND, c1);
        cfg_write(CFG_COEF_SECOND, c2);
        cfg_write(CFG_COEF_IMPULSE, c3);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        t_note_item it;
        int         made;
        made = 0;
        while (made < count) begin
            it = random_item();
            pending_items.push_back(it);
            if (it.mode != MODE_UNUSED) begin
                made++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TAB_SIZE; i++) begin
            sine_tab[i] = sine_entry(32'(i) << 22);
        end
        for (int v = 0; v < NV; v++) begin
            v_on[v]    = 1'b0;
            v_key[v]   = '0;
            v_loud[v]  = 0;
            v_phase[v] = '0;
            v_step[v]  = '0;
            v_harm[v]  = 0;
            v_integ[v] = 0;
            v_out[v]   = 0;
        end
        leak_q    = longint'(LEAK_RST);
        fund_q    = longint'(COEF_FUND_RST);
        second_q  = longint'(COEF_SECOND_RST);
        impulse_q = longint'(COEF_IMPULSE_RST);
        key_pool[0] = 32'd0;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 16; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: silent tick, field extremes, harmonic counts below and above three
        send_idle = 6;
        recv_idle = 82;
        pending_items.push_back(mk_item(MODE_TICK, '0, '0, '0, '0));
        pending_items.push_back(mk_item(MODE_NOTE_ON, 32'h7FFF_FFFF, 16'hFFFF,
                                        32'h8000_0000, 15'h7FFF));
        pending_items.push_back(mk_item(MODE_NOTE_ON, 32'h8000_0000, 16'h0000, 32'd0, 15'd0));
        pending_items.push_back(mk_item(MODE_NOTE_ON, 32'd5, 16'h8000, 32'd1, 15'd1));
        pending_items.push_back(mk_item(MODE_NOTE_ON, 32'd5, 16'd12345, 32'h0100_0000, 15'd2));
        pending_items.push_back(mk_item(MODE_NOTE_ON, 32'd9, 16'h5555, 32'h00A0_0000, 15'd40));
        repeat (3) pending_items.push_back(mk_item(MODE_TICK, '0, '0, '0, '0));
        // second off of a key hits the voice already off, the later twin keeps sounding
        pending_items.push_back(mk_item(MODE_NOTE_OFF, 32'd5, '0, '0, '0));
        pending_items.push_back(mk_item(MODE_NOTE_OFF, 32'd5, '0, '0, '0));
        pending_items.push_back(mk_item(MODE_NOTE_OFF, 32'd1234, '0, '0, '0));
        pending_items.push_back(mk_item(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                        15'h7FFF));
        pending_items.push_back(mk_item(MODE_TICK, '0, '0, '0, '0));
        // fill every voice, then one note-on too many
        for (int i = 0; i < 13; i++) begin
            pending_items.push_back(mk_item(MODE_NOTE_ON, 32'd100 + 32'(i), 16'($urandom),
                                            $urandom_range(32'h0200_0000, 0), 15'(3 + i)));
        end
        pending_items.push_back(mk_item(MODE_TICK, '0, '0, '0, '0));
        queue_random(PER_RUN - 27);
        wait_idle();

        // extremes, leak at unity
        cfg_all(24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
        send_idle = 82;
        recv_idle = 6;
        queue_random(PER_RUN);
        wait_idle();

        // opposite extremes, no leak
        cfg_all(24'h00_0000, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000);
        send_idle = 0;
        recv_idle = 0;
        queue_random(PER_RUN);
        wait_idle();

        $display("covered %0d ticks, %0d note-ons and %0d note-offs over three register settings",
                 n_ticks, n_on, n_off);
        $display("%0d samples checked, %0d mismatches", n_samples, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

endmodule
